// File: design/hxd_pkg.sv
// Package for the hex text to bytes decoder: character codes, status codes,
// shared structs and character classification functions. No dependencies.
`default_nettype none

package hxd_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LO_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    localparam logic [NIBBLE_W-1:0] LETTER_BIAS = 4'd9;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ODD_CNT = 2'd2;

    typedef struct packed {
        logic                is_skip;
        logic                is_hex;
        logic                is_zero;
        logic                is_x;
        logic [NIBBLE_W-1:0] nibble;
    } char_class_t;

    typedef struct packed {
        logic                has_result;
        logic [CHAR_W-1:0]   byte_value;
        logic                byte_valid;
        logic                frame_done;
        logic [STATUS_W-1:0] status;
    } result_t;

    function automatic logic is_skip_char(input logic [CHAR_W-1:0] c);
        logic hit;
        begin
            hit = 1'b0;
            if ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE)
            begin
                hit = 1'b1;
            end
            unique case (c)
                8'h2C, 8'h3B, 8'h3A, 8'h2D, 8'h5F, 8'h7C, 8'h2F,
                8'h5C, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h7B, 8'h7D,
                8'h3C, 8'h3E, 8'h27, 8'h22: hit = 1'b1;
                default: ;
            endcase
            return hit;
        end
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_LO_A && c <= CHAR_LO_F) || (c >= CHAR_UP_A && c <= CHAR_UP_F);
    endfunction

    // digits carry their value in the low nibble; a-f / A-F sit at 1..6
    function automatic logic [NIBBLE_W-1:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [NIBBLE_W-1:0] n;
        begin
            if (is_digit(c))
            begin
                n = c[NIBBLE_W-1:0];
            end
            else if (is_letter(c))
            begin
                n = c[NIBBLE_W-1:0] + LETTER_BIAS;
            end
            else
            begin
                n = '0;
            end
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/hex_text_to_bytes_decoder_core.sv
// Hex text to bytes decoder, one character per transaction.
// The input register takes the character, then the result register loads the
// step result and raises out_valid; a stalled output can delay that load.
// Throughput: one character per cycle; characters that yield no result retire
// without touching the output. Limited only by output backpressure.
// Reset: asynchronous active low; clears pipeline valids and frame state.
`default_nettype none

module hex_text_to_bytes_decoder_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output wire logic                          in_ready,
    input  wire logic [hxd_pkg::CHAR_W-1:0]    char_code,
    input  wire logic                          last_char,
    output wire logic                          out_valid,
    input  wire logic                          out_ready,
    output wire logic [hxd_pkg::CHAR_W-1:0]    byte_value,
    output wire logic                          byte_valid,
    output wire logic                          frame_done,
    output wire logic [hxd_pkg::STATUS_W-1:0]  status
);

    logic                        in_valid_reg;
    logic [hxd_pkg::CHAR_W-1:0]  char_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    hxd_pkg::result_t            out_reg;

    hxd_pkg::char_class_t        char_class;
    hxd_pkg::result_t            step_result;
    logic                        out_free;
    logic                        advance;

    hxd_char_class u_class (
        .char_code  (char_reg),
        .char_class (char_class)
    );

    hxd_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .char_class (char_class),
        .last_char  (last_reg),
        .result     (step_result)
    );

    assign out_free = !out_valid_reg || out_ready;
    // a character with no result retires even while the output is stalled
    assign advance  = in_valid_reg && (out_free || !step_result.has_result);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && step_result.has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (advance && step_result.has_result)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_value = out_reg.byte_value;
    assign byte_valid = out_reg.byte_valid;
    assign frame_done = out_reg.frame_done;
    assign status     = out_reg.status;

endmodule

`default_nettype wire

// File: design/hxd_char_class.sv
// Character classifier: splits one raw character into skip / hex / zero / x
// flags and its nibble value. Depends on hxd_pkg.
`default_nettype none

module hxd_char_class (
    input  wire logic [hxd_pkg::CHAR_W-1:0] char_code,
    output hxd_pkg::char_class_t            char_class
);

    always_comb
    begin
        char_class.is_skip = hxd_pkg::is_skip_char(char_code);
        char_class.is_hex  = hxd_pkg::is_digit(char_code) || hxd_pkg::is_letter(char_code);
        char_class.is_zero = (char_code == hxd_pkg::CHAR_ZERO);
        char_class.is_x    = (char_code == hxd_pkg::CHAR_LO_X) ||
                             (char_code == hxd_pkg::CHAR_UP_X);
        char_class.nibble  = hxd_pkg::nibble_of(char_code);
    end

endmodule

`default_nettype wire

// File: design/hxd_step.sv
// Per-character decode step: frame state registers (pending zero, held nibble,
// error) and the result for one character. Depends on hxd_pkg.
`default_nettype none

module hxd_step (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire hxd_pkg::char_class_t char_class,
    input  wire logic                last_char,
    output hxd_pkg::result_t         result
);

    logic                          zero_pending_reg, zero_pending_next;
    logic                          nibble_held_reg, nibble_held_next;
    logic [hxd_pkg::NIBBLE_W-1:0]  held_nibble_reg, held_nibble_next;
    logic                          error_latched_reg, error_latched_next;

    always_comb
    begin
        zero_pending_next  = zero_pending_reg;
        nibble_held_next   = nibble_held_reg;
        held_nibble_next   = held_nibble_reg;
        error_latched_next = error_latched_reg;
        result             = '0;

        if (!error_latched_reg)
        begin
            zero_pending_next = 1'b0;
            // held zero not consumed by an x prefix counts as a digit first
            if (zero_pending_reg && !char_class.is_x)
            begin
                if (nibble_held_next)
                begin
                    result.byte_valid = 1'b1;
                    result.byte_value = {held_nibble_next, {hxd_pkg::NIBBLE_W{1'b0}}};
                    nibble_held_next  = 1'b0;
                    held_nibble_next  = '0;
                end
                else
                begin
                    nibble_held_next = 1'b1;
                    held_nibble_next = '0;
                end
            end
            if (!(zero_pending_reg && char_class.is_x))
            begin
                priority if (char_class.is_skip)
                begin
                end
                else if (char_class.is_zero && !last_char)
                begin
                    zero_pending_next = 1'b1;
                end
                else if (char_class.is_hex)
                begin
                    if (nibble_held_next)
                    begin
                        result.byte_valid = 1'b1;
                        result.byte_value = {held_nibble_next, char_class.nibble};
                        nibble_held_next  = 1'b0;
                        held_nibble_next  = '0;
                    end
                    else
                    begin
                        nibble_held_next = 1'b1;
                        held_nibble_next = char_class.nibble;
                    end
                end
                else
                begin
                    error_latched_next = 1'b1;
                end
            end
        end

        if (last_char)
        begin
            result.frame_done = 1'b1;
            priority if (error_latched_next)
            begin
                result.status = hxd_pkg::STATUS_BAD_CHR;
            end
            else if (nibble_held_next)
            begin
                result.status = hxd_pkg::STATUS_ODD_CNT;
            end
            else
            begin
                result.status = hxd_pkg::STATUS_OK;
            end
            zero_pending_next  = 1'b0;
            nibble_held_next   = 1'b0;
            held_nibble_next   = '0;
            error_latched_next = 1'b0;
        end

        result.has_result = result.byte_valid || last_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_pending_reg  <= 1'b0;
            nibble_held_reg   <= 1'b0;
            held_nibble_reg   <= '0;
            error_latched_reg <= 1'b0;
        end
        else if (advance)
        begin
            zero_pending_reg  <= zero_pending_next;
            nibble_held_reg   <= nibble_held_next;
            held_nibble_reg   <= held_nibble_next;
            error_latched_reg <= error_latched_next;
        end
    end

endmodule

`default_nettype wire
